// File: rtl/core/foct_pkg.sv
// ----------------------------------------------------------------------------
// foct_pkg
// Shared types and constants for the frequency ordered counter table.
// ----------------------------------------------------------------------------
package foct_pkg;

	localparam int FOCT_CAPACITY = 64;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_SET  = 2'd1;

	localparam logic signed [31:0] COUNT_MAX = 32'sh7fff_ffff;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_BUB_RD,
		S_BUB_CMP,
		S_REM_RD,
		S_REM_WR,
		S_PL_RD,
		S_PL_CMP,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		C_NONE,
		C_LOAD,
		C_RD_IDX,
		C_RD_PREV,
		C_RD_NEXT,
		C_IDX_INC,
		C_HIT,
		C_RES_READ,
		C_INC,
		C_APPEND,
		C_REFUSE,
		C_PL_START,
		C_MOVE_DEC,
		C_MOVE_INC,
		C_BUB_FINAL,
		C_REM_END,
		C_PL_FOUND,
		C_SH_FINAL,
		C_EMIT
	} cmd_t;

	typedef struct packed {
		logic       idx_eq_n;
		logic       idx_zero;
		logic       idx_eq_q;
		logic       last_rem;
		logic       key_match;
		logic       cnt_less;
		logic       nv_greater;
		logic       found;
		logic       full;
		logic [1:0] kind;
		logic       out_free;
	} status_t;

endpackage

// File: rtl/core/foct_ctrl.sv
// ----------------------------------------------------------------------------
// foct_ctrl
// Sequencer for search, bubble, remove and place passes.
// ----------------------------------------------------------------------------
module foct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  foct_pkg::status_t st,
	output foct_pkg::cmd_t    cmd
);
	import foct_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = C_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = C_LOAD;
					state_d = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (st.idx_eq_n) state_d = S_DECIDE;
				else begin
					cmd     = C_RD_IDX;
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (st.key_match) begin
					cmd     = C_HIT;
					state_d = S_DECIDE;
				end else begin
					cmd     = C_IDX_INC;
					state_d = S_SRCH_RD;
				end
			end
			S_DECIDE: begin
				if (st.kind == KIND_ADD) begin
					if (st.found) begin
						cmd     = C_INC;
						state_d = S_BUB_RD;
					end else if (!st.full) begin
						cmd     = C_APPEND;
						state_d = S_DONE;
					end else begin
						cmd     = C_REFUSE;
						state_d = S_DONE;
					end
				end else if (st.kind == KIND_SET) begin
					if (st.found) state_d = S_REM_RD;
					else if (!st.full) begin
						cmd     = C_PL_START;
						state_d = S_PL_RD;
					end else begin
						cmd     = C_REFUSE;
						state_d = S_DONE;
					end
				end else begin
					cmd     = C_RES_READ;
					state_d = S_DONE;
				end
			end
			S_BUB_RD: begin
				if (st.idx_zero) begin
					cmd     = C_BUB_FINAL;
					state_d = S_DONE;
				end else begin
					cmd     = C_RD_PREV;
					state_d = S_BUB_CMP;
				end
			end
			S_BUB_CMP: begin
				if (st.cnt_less) begin
					cmd     = C_MOVE_DEC;
					state_d = S_BUB_RD;
				end else begin
					cmd     = C_BUB_FINAL;
					state_d = S_DONE;
				end
			end
			S_REM_RD: begin
				if (st.last_rem) begin
					cmd     = C_REM_END;
					state_d = S_PL_RD;
				end else begin
					cmd     = C_RD_NEXT;
					state_d = S_REM_WR;
				end
			end
			S_REM_WR: begin
				cmd     = C_MOVE_INC;
				state_d = S_REM_RD;
			end
			S_PL_RD: begin
				if (st.idx_eq_n) begin
					cmd     = C_PL_FOUND;
					state_d = S_SH_RD;
				end else begin
					cmd     = C_RD_IDX;
					state_d = S_PL_CMP;
				end
			end
			S_PL_CMP: begin
				if (st.nv_greater) begin
					cmd     = C_PL_FOUND;
					state_d = S_SH_RD;
				end else begin
					cmd     = C_IDX_INC;
					state_d = S_PL_RD;
				end
			end
			S_SH_RD: begin
				if (st.idx_eq_q) begin
					cmd     = C_SH_FINAL;
					state_d = S_DONE;
				end else begin
					cmd     = C_RD_PREV;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd     = C_MOVE_DEC;
				state_d = S_SH_RD;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd     = C_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/core/foct_dp.sv
// ----------------------------------------------------------------------------
// foct_dp
// Key and count memories, pointers, working registers and result register.
// ----------------------------------------------------------------------------
module foct_dp #(
	parameter int CAPACITY = foct_pkg::FOCT_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  foct_pkg::cmd_t     cmd,
	output foct_pkg::status_t  st,
	input  logic [1:0]         kind,
	input  logic [31:0]        key,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] count,
	output logic [5:0]         rank,
	output logic               was_present,
	output logic               refused,
	output logic [6:0]         entries
);
	import foct_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]        key_mem [CAPACITY];
	logic signed [31:0] cnt_mem [CAPACITY];

	logic [CW-1:0]      idx_q, n_q, pos_q;
	logic [1:0]         kind_q;
	logic [31:0]        key_q;
	logic signed [31:0] nv_q, cur_q;
	logic               found_q;
	logic [31:0]        rd_key_q;
	logic signed [31:0] rd_cnt_q;

	logic signed [31:0] res_cnt_q;
	logic [5:0]         res_rank_q;
	logic               res_pres_q, res_ref_q;

	logic               rd_en, wr_en;
	logic [CW-1:0]      rd_ptr, wr_ptr;
	logic [31:0]        wr_key;
	logic signed [31:0] wr_cnt;
	logic [CW-1:0]      idx_p1, idx_m1;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);

	always_comb begin
		rd_en  = 1'b0;
		rd_ptr = idx_q;
		wr_en  = 1'b0;
		wr_ptr = idx_q;
		wr_key = rd_key_q;
		wr_cnt = rd_cnt_q;
		unique case (cmd)
			C_RD_IDX:  rd_en = 1'b1;
			C_RD_PREV: begin
				rd_en  = 1'b1;
				rd_ptr = idx_m1;
			end
			C_RD_NEXT: begin
				rd_en  = 1'b1;
				rd_ptr = idx_p1;
			end
			C_MOVE_DEC, C_MOVE_INC: wr_en = 1'b1;
			C_APPEND: begin
				wr_en  = 1'b1;
				wr_ptr = n_q;
				wr_key = key_q;
				wr_cnt = 32'sd1;
			end
			C_BUB_FINAL: begin
				wr_en  = 1'b1;
				wr_key = key_q;
				wr_cnt = cur_q;
			end
			C_SH_FINAL: begin
				wr_en  = 1'b1;
				wr_ptr = pos_q;
				wr_key = key_q;
				wr_cnt = nv_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_ptr[AW-1:0]];
			rd_cnt_q <= cnt_mem[rd_ptr[AW-1:0]];
		end
		if (wr_en) begin
			key_mem[wr_ptr[AW-1:0]] <= wr_key;
			cnt_mem[wr_ptr[AW-1:0]] <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd == C_APPEND || cmd == C_SH_FINAL) n_q <= n_q + CW'(1);
			else if (cmd == C_REM_END)                n_q <= n_q - CW'(1);
			if (cmd == C_EMIT)                        out_valid <= 1'b1;
			else if (out_ready)                       out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			C_LOAD: begin
				kind_q  <= kind;
				key_q   <= key;
				nv_q    <= new_value;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			C_IDX_INC, C_MOVE_INC: idx_q <= idx_p1;
			C_MOVE_DEC:            idx_q <= idx_m1;
			C_HIT: begin
				pos_q   <= idx_q;
				cur_q   <= rd_cnt_q;
				found_q <= 1'b1;
			end
			C_INC: if (cur_q != COUNT_MAX) cur_q <= cur_q + 32'sd1;
			C_PL_START, C_REM_END: idx_q <= '0;
			C_PL_FOUND: begin
				pos_q <= idx_q;
				idx_q <= n_q;
			end
			default: ;
		endcase
		unique case (cmd)
			C_RES_READ: begin
				res_cnt_q  <= found_q ? cur_q : 32'sd0;
				res_rank_q <= found_q ? 6'(pos_q) : 6'd0;
				res_pres_q <= found_q;
				res_ref_q  <= 1'b0;
			end
			C_APPEND: begin
				res_cnt_q  <= 32'sd1;
				res_rank_q <= 6'(n_q);
				res_pres_q <= 1'b0;
				res_ref_q  <= 1'b0;
			end
			C_REFUSE: begin
				res_cnt_q  <= 32'sd0;
				res_rank_q <= 6'd0;
				res_pres_q <= 1'b0;
				res_ref_q  <= 1'b1;
			end
			C_BUB_FINAL: begin
				res_cnt_q  <= cur_q;
				res_rank_q <= 6'(idx_q);
				res_pres_q <= 1'b1;
				res_ref_q  <= 1'b0;
			end
			C_SH_FINAL: begin
				res_cnt_q  <= nv_q;
				res_rank_q <= 6'(pos_q);
				res_pres_q <= found_q;
				res_ref_q  <= 1'b0;
			end
			default: ;
		endcase
		if (cmd == C_EMIT) begin
			count       <= res_cnt_q;
			rank        <= res_rank_q;
			was_present <= res_pres_q;
			refused     <= res_ref_q;
			entries     <= 7'(n_q);
		end
	end

	always_comb begin
		st.idx_eq_n   = (idx_q == n_q);
		st.idx_zero   = (idx_q == '0);
		st.idx_eq_q   = (idx_q == pos_q);
		st.last_rem   = (idx_p1 >= n_q);
		st.key_match  = (rd_key_q == key_q);
		st.cnt_less   = (rd_cnt_q < cur_q);
		st.nv_greater = (nv_q > rd_cnt_q);
		st.found      = found_q;
		st.full       = (n_q >= CW'(CAPACITY));
		st.kind       = kind_q;
		st.out_free   = !out_valid || out_ready;
	end

	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(CAPACITY)) else $error("entry total above capacity");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == C_APPEND || cmd == C_SH_FINAL) |-> n_q < CW'(CAPACITY))
		else $error("insert into full table");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == C_EMIT |-> (!out_valid || out_ready))
		else $error("result overwritten");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == C_EMIT |=> out_valid) else $error("result not shown");

endmodule

// File: rtl/core/frequency_ordered_counter_table.sv
// ----------------------------------------------------------------------------
// frequency_ordered_counter_table
// Table of (key, count) entries kept in descending count order.
//
//   channel  signals                                   role
//   in       in_valid in_ready kind key new_value      operation item
//   out      out_valid out_ready count rank
//            was_present refused entries               result item
//
// One item at a time. Search reads the key memory one entry at a time;
// bubble, remove and place passes move one entry at a time over the
// single-port memories. Reset clears the entry total, the result valid flag
// and the sequencer state; no clearing pass.
// The next item is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module frequency_ordered_counter_table #(
	parameter int CAPACITY = foct_pkg::FOCT_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [31:0]        key,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] count,
	output logic [5:0]         rank,
	output logic               was_present,
	output logic               refused,
	output logic [6:0]         entries
);
	import foct_pkg::*;

	cmd_t    cmd;
	status_t st;

	foct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	foct_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.kind        (kind),
		.key         (key),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count       (count),
		.rank        (rank),
		.was_present (was_present),
		.refused     (refused),
		.entries     (entries)
	);

endmodule
